FILE: hdl/rmbr_pkg.sv
// Shared constants, types and command structs for the raster to block reorder.
`default_nettype none
package rmbr_pkg;
    localparam int MAX_WIDTH  = 2048;
    localparam int BLOCK_SIDE = 8;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(BLOCK_SIDE);
    localparam int ADDR_W     = COL_W + ROW_W;
    localparam int DEPTH      = BLOCK_SIDE * MAX_WIDTH;
    localparam int EW_W       = $clog2(MAX_WIDTH + 1);
    localparam int PX_W       = 24;
    localparam int BEAT_W     = 6;
    localparam logic [BEAT_W-1:0] BEAT_LAST = 6'd63;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_PULL  = 1'b1;

    typedef enum logic [2:0] {
        CFG_IMAGE_WIDTH   = 3'd0,
        CFG_IMAGE_HEIGHT  = 3'd1,
        CFG_COLOR_MODE    = 3'd2,
        CFG_WIDTH_FACTOR  = 3'd3,
        CFG_HEIGHT_FACTOR = 3'd4
    } cfg_idx_t;

    typedef enum logic {
        ST_IDLE,
        ST_STREAM
    } state_t;

    typedef struct packed {
        logic              write;
        logic              pull;
        logic              issue;
        logic [BEAT_W-1:0] beat;
    } ctrl_cmd_t;

    typedef struct packed {
        logic pull_ok;
        logic advance;
    } ctrl_stat_t;
endpackage
`default_nettype wire

FILE: hdl/rmbr_req_if.sv
// Input channel: raster pixel writes and block pull requests.
`default_nettype none
interface rmbr_req_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] in_comp_a;
    logic [7:0] in_comp_b;
    logic [7:0] in_comp_c;

    modport source (output valid, func, in_comp_a, in_comp_b, in_comp_c, input ready);
    modport sink (input valid, func, in_comp_a, in_comp_b, in_comp_c, output ready);
endinterface
`default_nettype wire

FILE: hdl/rmbr_blk_if.sv
// Output channel: block pixels with their block position and flags.
`default_nettype none
interface rmbr_blk_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_comp_a;
    logic [7:0]  out_comp_b;
    logic [7:0]  out_comp_c;
    logic [7:0]  block_column;
    logic [12:0] block_row;
    logic        last_in_block;
    logic        last_of_image;
    logic        overrun;

    modport source (output valid, out_comp_a, out_comp_b, out_comp_c, block_column,
                    block_row, last_in_block, last_of_image, overrun, input ready);
    modport sink (input valid, out_comp_a, out_comp_b, out_comp_c, block_column,
                  block_row, last_in_block, last_of_image, overrun, output ready);
endinterface
`default_nettype wire

FILE: hdl/raster_to_mcu_block_reorder.sv
// Top level of the raster to 8x8 block reorder.
// Pixel write beats (func 0) go into an eight-row band memory; once a band is
// complete, each pull beat (func 1) returns the next 8x8 block as 64 output
// beats, row-major, with edge columns and rows padded by copying. A pull holds
// the input side until its band memory reads are all issued, one band memory
// read per output beat through its single read port, and each read passes the
// band memory read register and the output register before its beat appears.
// While an output beat is held by a stall, the input side also waits.
// Pixels written while a band waits to be drained are dropped and set the
// sticky overrun flag, which only reset clears. Configuration is to be written
// by the user only while the block is idle; the block does not enforce it.
`default_nettype none
module raster_to_mcu_block_reorder (
    input  wire logic        clk,
    input  wire logic        rst_n,
    rmbr_req_if.sink         req_ch,
    rmbr_blk_if.source       blk_ch,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    rmbr_pkg::ctrl_cmd_t  cmd;
    rmbr_pkg::ctrl_stat_t stat;
    logic                 req_ready;

    assign req_ch.ready = req_ready;

    rmbr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_ch.valid),
        .req_func  (req_ch.func),
        .stat      (stat),
        .req_ready (req_ready),
        .cmd       (cmd)
    );

    rmbr_dpath u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .cmd           (cmd),
        .px_a          (req_ch.in_comp_a),
        .px_b          (req_ch.in_comp_b),
        .px_c          (req_ch.in_comp_c),
        .out_ready     (blk_ch.ready),
        .stat          (stat),
        .out_valid     (blk_ch.valid),
        .out_comp_a    (blk_ch.out_comp_a),
        .out_comp_b    (blk_ch.out_comp_b),
        .out_comp_c    (blk_ch.out_comp_c),
        .block_column  (blk_ch.block_column),
        .block_row     (blk_ch.block_row),
        .last_in_block (blk_ch.last_in_block),
        .last_of_image (blk_ch.last_of_image),
        .overrun       (blk_ch.overrun)
    );
endmodule
`default_nettype wire

FILE: hdl/rmbr_ram.sv
// Generic single write port, single read port RAM with registered read.
`default_nettype none
module rmbr_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16384
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

FILE: hdl/rmbr_ctrl.sv
// Controller: accepts beats and sequences the 64 band reads of a block pull.
`default_nettype none
module rmbr_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 req_valid,
    input  wire logic                 req_func,
    input  wire rmbr_pkg::ctrl_stat_t stat,
    output logic                      req_ready,
    output rmbr_pkg::ctrl_cmd_t       cmd
);
    rmbr_pkg::state_t                 state_reg, state_next;
    logic [rmbr_pkg::BEAT_W-1:0]      beat_reg, beat_next;
    logic                             pull_start;

    assign pull_start = (state_reg == rmbr_pkg::ST_IDLE) && req_valid && stat.advance
                        && (req_func == rmbr_pkg::FUNC_PULL) && stat.pull_ok;

    always_comb
    begin
        state_next = state_reg;
        beat_next  = beat_reg;
        case (state_reg)
            rmbr_pkg::ST_IDLE:
            begin
                beat_next = '0;
                if (pull_start)
                begin
                    state_next = rmbr_pkg::ST_STREAM;
                end
            end
            rmbr_pkg::ST_STREAM:
            begin
                if (stat.advance)
                begin
                    beat_next = beat_reg + 1'b1;
                    if (beat_reg == rmbr_pkg::BEAT_LAST)
                    begin
                        state_next = rmbr_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = rmbr_pkg::ST_IDLE;
            end
        endcase
    end

    // Input beats wait while a held output beat stalls the output stage.
    always_comb
    begin
        req_ready = 1'b0;
        cmd       = '0;
        cmd.beat  = beat_reg;
        case (state_reg)
            rmbr_pkg::ST_IDLE:
            begin
                req_ready = stat.advance;
                cmd.write = req_valid && stat.advance && (req_func == rmbr_pkg::FUNC_WRITE);
                cmd.pull  = pull_start;
            end
            rmbr_pkg::ST_STREAM:
            begin
                cmd.issue = stat.advance;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rmbr_pkg::ST_IDLE;
            beat_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            beat_reg  <= beat_next;
        end
    end

    a_stream_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.issue && beat_reg == rmbr_pkg::BEAT_LAST) |=> state_reg == rmbr_pkg::ST_IDLE)
        else $error("Stream did not end after the last beat.");
    a_pull_starts: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pull |=> (state_reg == rmbr_pkg::ST_STREAM && beat_reg == '0))
        else $error("Accepted pull did not start a stream at beat zero.");
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req_ready |-> state_reg == rmbr_pkg::ST_IDLE)
        else $error("Input ready outside the idle state.");
endmodule
`default_nettype wire

FILE: hdl/rmbr_dpath.sv
// Datapath: configuration, write and emit positions, band memory and output stage.
`default_nettype none
module rmbr_dpath (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [2:0]           cfg_index,
    input  wire logic [15:0]          cfg_data,
    input  wire rmbr_pkg::ctrl_cmd_t  cmd,
    input  wire logic [7:0]           px_a,
    input  wire logic [7:0]           px_b,
    input  wire logic [7:0]           px_c,
    input  wire logic                 out_ready,
    output rmbr_pkg::ctrl_stat_t      stat,
    output logic                      out_valid,
    output logic [7:0]                out_comp_a,
    output logic [7:0]                out_comp_b,
    output logic [7:0]                out_comp_c,
    output logic [7:0]                block_column,
    output logic [12:0]               block_row,
    output logic                      last_in_block,
    output logic                      last_of_image,
    output logic                      overrun
);
    logic [11:0] iw_reg;
    logic [15:0] ih_reg;
    logic        cm_reg;
    logic [2:0]  wf_reg;
    logic [2:0]  hf_reg;

    logic [rmbr_pkg::COL_W-1:0] wc_reg, wc_next;
    logic [15:0] wr_reg, wr_next;
    logic        band_reg, band_next;
    logic        extra_reg, extra_next;
    logic [7:0]  ecol_reg, ecol_next;
    logic [12:0] erow_reg, erow_next;
    logic        ovr_reg, ovr_next;

    logic [7:0]  lat_col_reg;
    logic [12:0] lat_row_reg;
    logic        lat_extra_reg;
    logic [2:0]  lat_lastr_reg;
    logic        lat_img_reg;
    logic        lat_ovr_reg;

    logic        s1_v_reg;
    logic        s1_lb_reg;
    logic        s1_li_reg;
    logic        out_v_reg;

    logic [rmbr_pkg::EW_W-1:0]   w;
    logic [15:0]                 h;
    logic [8:0]                  ncols;
    logic [16:0]                 hsum;
    logic                        needs_extra;
    logic [2:0]                  lastr;
    logic                        last_col;
    logic                        final_band;
    logic                        last_img;
    logic                        busy_band;
    logic                        wr_en;
    logic [rmbr_pkg::PX_W-1:0]   px;
    logic [2:0]                  rd_r;
    logic [2:0]                  rd_rr;
    logic [10:0]                 rd_colx;
    logic [10:0]                 rd_col;
    logic [rmbr_pkg::ADDR_W-1:0] raddr;
    logic [rmbr_pkg::PX_W-1:0]   rdata;
    logic                        advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iw_reg <= 12'd8;
            ih_reg <= 16'd8;
            cm_reg <= 1'b1;
            wf_reg <= 3'd1;
            hf_reg <= 3'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rmbr_pkg::CFG_IMAGE_WIDTH:   iw_reg <= cfg_data[11:0];
                rmbr_pkg::CFG_IMAGE_HEIGHT:  ih_reg <= cfg_data;
                rmbr_pkg::CFG_COLOR_MODE:    cm_reg <= cfg_data[0];
                rmbr_pkg::CFG_WIDTH_FACTOR:  wf_reg <= cfg_data[2:0];
                rmbr_pkg::CFG_HEIGHT_FACTOR: hf_reg <= cfg_data[2:0];
                default:                     iw_reg <= iw_reg;
            endcase
        end
    end

    always_comb
    begin
        if (iw_reg == '0)
        begin
            w = rmbr_pkg::EW_W'(1);
        end
        else if (32'(iw_reg) > rmbr_pkg::MAX_WIDTH)
        begin
            w = rmbr_pkg::EW_W'(rmbr_pkg::MAX_WIDTH);
        end
        else
        begin
            w = rmbr_pkg::EW_W'(iw_reg);
        end
        h = (ih_reg == '0) ? 16'd1 : ih_reg;
        ncols = 9'((32'(w) + 32'd7) >> 3);
        if (cm_reg && wf_reg == 3'd2 && ncols[0])
        begin
            ncols = ncols + 9'd1;
        end
        hsum        = {1'b0, h} + 17'd7;
        needs_extra = cm_reg && (hf_reg == 3'd2) && hsum[3];
        lastr       = wr_reg[2:0] - 3'd1;
        last_col    = ({1'b0, ecol_reg} + 9'd1) >= ncols;
        final_band  = (wr_reg >= h) || (wr_reg == '0);
        last_img    = last_col && (extra_reg || (final_band && !needs_extra));
        busy_band   = band_reg || extra_reg;
        wr_en       = cmd.write && !busy_band;
        px          = {cm_reg ? px_c : 8'd0, cm_reg ? px_b : 8'd0, px_a};
    end

    always_comb
    begin
        wc_next    = wc_reg;
        wr_next    = wr_reg;
        band_next  = band_reg;
        extra_next = extra_reg;
        ecol_next  = ecol_reg;
        erow_next  = erow_reg;
        ovr_next   = ovr_reg;
        if (cmd.write && busy_band)
        begin
            ovr_next = 1'b1;
        end
        if (wr_en)
        begin
            if ((32'(wc_reg) + 32'd1) >= 32'(w))
            begin
                wc_next = '0;
                if (wr_reg[2:0] == 3'd7 || ({1'b0, wr_reg} + 17'd1) >= {1'b0, h})
                begin
                    band_next = 1'b1;
                end
                wr_next = wr_reg + 16'd1;
            end
            else
            begin
                wc_next = wc_reg + 1'b1;
            end
        end
        if (cmd.pull)
        begin
            if (!last_col)
            begin
                ecol_next = ecol_reg + 8'd1;
            end
            else if (last_img || extra_reg)
            begin
                wc_next    = '0;
                wr_next    = '0;
                ecol_next  = '0;
                erow_next  = '0;
                band_next  = 1'b0;
                extra_next = 1'b0;
            end
            else
            begin
                ecol_next = '0;
                erow_next = erow_reg + 13'd1;
                band_next = 1'b0;
                if (final_band)
                begin
                    extra_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wc_reg    <= '0;
            wr_reg    <= '0;
            band_reg  <= 1'b0;
            extra_reg <= 1'b0;
            ecol_reg  <= '0;
            erow_reg  <= '0;
            ovr_reg   <= 1'b0;
        end
        else
        begin
            wc_reg    <= wc_next;
            wr_reg    <= wr_next;
            band_reg  <= band_next;
            extra_reg <= extra_next;
            ecol_reg  <= ecol_next;
            erow_reg  <= erow_next;
            ovr_reg   <= ovr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pull)
        begin
            lat_col_reg   <= ecol_reg;
            lat_row_reg   <= erow_reg;
            lat_extra_reg <= extra_reg;
            lat_lastr_reg <= lastr;
            lat_img_reg   <= last_img;
            lat_ovr_reg   <= ovr_reg;
        end
    end

    // The block pixel row is clamped to the last band row (every row uses it in an
    // extra band), and columns past the image edge repeat the last real column.
    always_comb
    begin
        rd_r    = cmd.beat[5:3];
        rd_rr   = (lat_extra_reg || rd_r >= lat_lastr_reg) ? lat_lastr_reg : rd_r;
        rd_colx = {lat_col_reg, cmd.beat[2:0]};
        rd_col  = (32'(rd_colx) >= 32'(w)) ? 11'(w - 1'b1) : rd_colx;
        raddr   = {rd_rr, rmbr_pkg::COL_W'(rd_col)};
    end

    rmbr_ram #(
        .WIDTH (rmbr_pkg::PX_W),
        .DEPTH (rmbr_pkg::DEPTH)
    ) u_band_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr ({wr_reg[2:0], wc_reg}),
        .wdata (px),
        .re    (cmd.issue),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign advance      = !out_v_reg || out_ready;
    assign stat.advance = advance;
    assign stat.pull_ok = busy_band;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_v_reg  <= cmd.issue;
            out_v_reg <= s1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if (cmd.issue)
            begin
                s1_lb_reg <= (cmd.beat == rmbr_pkg::BEAT_LAST);
                s1_li_reg <= (cmd.beat == rmbr_pkg::BEAT_LAST) && lat_img_reg;
            end
            if (s1_v_reg)
            begin
                out_comp_a    <= rdata[7:0];
                out_comp_b    <= cm_reg ? rdata[15:8] : 8'd0;
                out_comp_c    <= cm_reg ? rdata[23:16] : 8'd0;
                block_column  <= lat_col_reg;
                block_row     <= lat_row_reg;
                last_in_block <= s1_lb_reg;
                last_of_image <= s1_li_reg;
                overrun       <= lat_ovr_reg;
            end
        end
    end

    assign out_valid = out_v_reg;

    a_band_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(band_reg && extra_reg))
        else $error("Band ready and extra band pending are both set.");
    a_last_img: assert property (@(posedge clk) disable iff (!rst_n)
        (out_v_reg && last_of_image) |-> last_in_block)
        else $error("Image end flagged away from a block end.");
    a_no_pull_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pull |-> !s1_v_reg || advance)
        else $error("Pull accepted while a read beat is held.");
endmodule
`default_nettype wire
